FILE: rtl/lcr_pkg.sv
package lcr_pkg;

  // number formats
  localparam int FRAC_BITS = 16;
  localparam int FIELD_W   = 32;
  localparam int CUT_W     = 16;

  // derived widths
  localparam int MAG_W    = FIELD_W + 1;                 // sqrt of three squares
  localparam int THR_W    = MAG_W + FRAC_BITS + 1;       // threshold, hdr doubles
  localparam int DISC_W   = THR_W + FIELD_W + 3;         // l^2 + 4*q*t
  localparam int SQ_W     = DISC_W + (DISC_W % 2);       // even root operand
  localparam int ROOT_W   = SQ_W / 2;
  localparam int MUL_H    = (THR_W + 1) / 2;             // threshold split for q*t
  localparam int MUL_HI_W = THR_W - MUL_H;
  localparam int T_W      = FIELD_W + THR_W;
  localparam int NUM_W    = THR_W;                       // final numerator
  localparam int TOP_W    = NUM_W + FRAC_BITS - FIELD_W;
  localparam int DIV_W    = FIELD_W + 1;                 // divisor up to 2*q
  localparam int CMP_W    = (TOP_W > DIV_W) ? TOP_W : DIV_W;

  // pipeline stage map
  localparam int ST_R1    = 3;                           // after the three squares
  localparam int ST_TC    = ST_R1 + ROOT_W;              // threshold divide setup
  localparam int ST_DEC   = ST_TC + 1 + THR_W;           // decode and products
  localparam int ST_R2    = ST_DEC + 6;                  // discriminant root
  localparam int ST_FS    = ST_R2 + ROOT_W;              // final divide setup
  localparam int ST_FD    = ST_FS + 2;
  localparam int DEPTH    = ST_FD + FIELD_W;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_MODE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_LEVEL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_RADIUS = 2'd2;

  localparam logic [CUT_W-1:0]   RESET_CUTOFF   = 16'd1966;
  localparam logic [FIELD_W-1:0] RESET_FALLBACK = 32'd131072000;

  typedef enum logic [2:0] {
    MODE_BYPASS,
    MODE_FALLBACK,
    MODE_ZERO,
    MODE_LINEAR,
    MODE_QUAD
  } lcr_mode_t;

  typedef struct packed {
    logic [ROOT_W+1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic               hdr;
    logic [CUT_W-1:0]   cutoff;
    logic [FIELD_W-1:0] fallback;
  } lcr_cfg_t;

  typedef struct packed {
    logic [FIELD_W-1:0] radius;
    logic               used_fallback;
    logic               clipped;
  } lcr_result_t;

  typedef struct packed {
    logic [FIELD_W-1:0]          preset;
    logic [FIELD_W-1:0]          ir;
    logic [FIELD_W-1:0]          ig;
    logic [FIELD_W-1:0]          ib;
    logic [FIELD_W-1:0]          ac;
    logic [FIELD_W-1:0]          al;
    logic [FIELD_W-1:0]          aq;
    lcr_mode_t                   mode;
    logic [SQ_W-1:0]             acc;
    sqrt_st_t                    ss;
    logic [THR_W-1:0]            dnum;
    logic [THR_W-1:0]            thr;
    logic [DIV_W-1:0]            dv;
    logic [DIV_W-1:0]            drem;
    logic [2*FIELD_W-1:0]        p1;
    logic [FIELD_W+MUL_H-1:0]    p2;
    logic [FIELD_W+MUL_HI_W-1:0] p3;
    logic [T_W-1:0]              t;
    logic [2*FIELD_W-1:0]        p4;
    logic [DISC_W-1:0]           pos;
    logic [DISC_W-1:0]           neg;
    logic [NUM_W-1:0]            numer;
    logic [FIELD_W-1:0]          fnum;
    logic [FIELD_W-1:0]          q;
    logic                        sat;
  } lcr_item_t;

  // one result bit of a digit-by-digit square root
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input logic [1:0] pair);
    logic [ROOT_W+3:0] r2;
    logic [ROOT_W+3:0] trial;
    sqrt_st_t          o;
    r2    = {s.rem, pair};
    trial = {2'b00, s.root, 2'b01};
    if (r2 >= trial) begin
      o.rem  = (ROOT_W+2)'(r2 - trial);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = (ROOT_W+2)'(r2);
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // one quotient bit of a restoring divide, returns {remainder, bit}
  function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                              input logic [DIV_W-1:0] d,
                                              input logic b);
    logic [DIV_W:0] t;
    t = {rem, b};
    if (t >= {1'b0, d}) begin
      return {DIV_W'(t - {1'b0, d}), 1'b1};
    end else begin
      return {t[DIV_W-1:0], 1'b0};
    end
  endfunction

endpackage

FILE: rtl/lcr_pipe.sv
module lcr_pipe (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  lcr_pkg::lcr_item_t   in_item,
  input  lcr_pkg::lcr_cfg_t    cfg,
  output logic                 out_vld,
  output lcr_pkg::lcr_result_t out_res
);

  lcr_pkg::lcr_item_t st [lcr_pkg::DEPTH];
  lcr_pkg::lcr_item_t nx [lcr_pkg::DEPTH];
  lcr_pkg::lcr_item_t cur [lcr_pkg::DEPTH];
  logic               vld [lcr_pkg::DEPTH];
  logic               cur_vld [lcr_pkg::DEPTH];

  for (genvar s = 0; s < lcr_pkg::DEPTH; s++) begin : g_st
    if (s == 0) begin : g_first
      assign cur[s]     = in_item;
      assign cur_vld[s] = in_vld;
    end else begin : g_next
      assign cur[s]     = st[s-1];
      assign cur_vld[s] = vld[s-1];
    end

    always_comb begin
      logic [2*lcr_pkg::FIELD_W-1:0] prod;
      logic [lcr_pkg::DIV_W:0]       dr;
      logic [lcr_pkg::CMP_W-1:0]     top;
      nx[s] = cur[s];
      prod  = '0;
      dr    = '0;
      top   = '0;
      if (s == 0) begin
        prod       = (2*lcr_pkg::FIELD_W)'(cur[s].ir) * (2*lcr_pkg::FIELD_W)'(cur[s].ir);
        nx[s].acc  = lcr_pkg::SQ_W'(prod);
      end else if (s == 1) begin
        prod       = (2*lcr_pkg::FIELD_W)'(cur[s].ig) * (2*lcr_pkg::FIELD_W)'(cur[s].ig);
        nx[s].acc  = cur[s].acc + lcr_pkg::SQ_W'(prod);
      end else if (s == 2) begin
        prod       = (2*lcr_pkg::FIELD_W)'(cur[s].ib) * (2*lcr_pkg::FIELD_W)'(cur[s].ib);
        nx[s].acc  = cur[s].acc + lcr_pkg::SQ_W'(prod);
        nx[s].ss   = '0;
      end else if ((s < lcr_pkg::ST_TC) ||
                   (s >= lcr_pkg::ST_R2 && s < lcr_pkg::ST_FS)) begin
        // square root, one result bit per stage
        nx[s].ss  = lcr_pkg::sqrt_step(cur[s].ss, cur[s].acc[lcr_pkg::SQ_W-1 -: 2]);
        nx[s].acc = cur[s].acc << 2;
      end else if (s == lcr_pkg::ST_TC) begin
        nx[s].dnum = lcr_pkg::THR_W'(cur[s].ss.root[lcr_pkg::MAG_W-1:0]) << lcr_pkg::FRAC_BITS;
        if (cfg.hdr) begin
          nx[s].dnum = nx[s].dnum << 1;
        end
        nx[s].dv   = (cfg.cutoff == '0) ? lcr_pkg::DIV_W'(1) : lcr_pkg::DIV_W'(cfg.cutoff);
        nx[s].drem = '0;
        nx[s].thr  = '0;
      end else if (s < lcr_pkg::ST_DEC) begin
        // threshold divide, one quotient bit per stage
        dr          = lcr_pkg::div_step(cur[s].drem, cur[s].dv, cur[s].dnum[lcr_pkg::THR_W-1]);
        nx[s].drem  = dr[lcr_pkg::DIV_W:1];
        nx[s].thr   = {cur[s].thr[lcr_pkg::THR_W-2:0], dr[0]};
        nx[s].dnum  = cur[s].dnum << 1;
      end else if (s == lcr_pkg::ST_DEC) begin
        if (cur[s].preset != '0) begin
          nx[s].mode = lcr_pkg::MODE_BYPASS;
        end else if (cur[s].aq == '0 && cur[s].al == '0) begin
          nx[s].mode = lcr_pkg::MODE_FALLBACK;
        end else if (cur[s].aq == '0) begin
          nx[s].mode = lcr_pkg::MODE_LINEAR;
        end else begin
          nx[s].mode = lcr_pkg::MODE_QUAD;
        end
        nx[s].p1 = (2*lcr_pkg::FIELD_W)'(cur[s].al) * (2*lcr_pkg::FIELD_W)'(cur[s].al);
      end else if (s == lcr_pkg::ST_DEC + 1) begin
        nx[s].p2 = {{lcr_pkg::MUL_H{1'b0}}, cur[s].aq} *
                   {{lcr_pkg::FIELD_W{1'b0}}, cur[s].thr[lcr_pkg::MUL_H-1:0]};
      end else if (s == lcr_pkg::ST_DEC + 2) begin
        nx[s].p3 = {{lcr_pkg::MUL_HI_W{1'b0}}, cur[s].aq} *
                   {{lcr_pkg::FIELD_W{1'b0}}, cur[s].thr[lcr_pkg::THR_W-1:lcr_pkg::MUL_H]};
        if (cur[s].mode == lcr_pkg::MODE_LINEAR) begin
          if (cur[s].thr < lcr_pkg::THR_W'(cur[s].ac)) begin
            nx[s].mode = lcr_pkg::MODE_ZERO;
          end else begin
            nx[s].numer = lcr_pkg::NUM_W'(cur[s].thr - lcr_pkg::THR_W'(cur[s].ac));
          end
        end
      end else if (s == lcr_pkg::ST_DEC + 3) begin
        nx[s].t  = (lcr_pkg::T_W'(cur[s].p3) << lcr_pkg::MUL_H) + lcr_pkg::T_W'(cur[s].p2);
        nx[s].p4 = (2*lcr_pkg::FIELD_W)'(cur[s].aq) * (2*lcr_pkg::FIELD_W)'(cur[s].ac);
      end else if (s == lcr_pkg::ST_DEC + 4) begin
        nx[s].pos = lcr_pkg::DISC_W'(cur[s].p1) + (lcr_pkg::DISC_W'(cur[s].t) << 2);
        nx[s].neg = lcr_pkg::DISC_W'(cur[s].p4) << 2;
      end else if (s == lcr_pkg::ST_DEC + 5) begin
        nx[s].ss = '0;
        if (cur[s].mode == lcr_pkg::MODE_QUAD) begin
          if (cur[s].pos < cur[s].neg) begin
            nx[s].mode = lcr_pkg::MODE_FALLBACK;
          end else begin
            nx[s].acc = lcr_pkg::SQ_W'(cur[s].pos - cur[s].neg);
          end
        end
      end else if (s == lcr_pkg::ST_FS) begin
        if (cur[s].mode == lcr_pkg::MODE_QUAD) begin
          if (cur[s].ss.root < lcr_pkg::ROOT_W'(cur[s].al)) begin
            nx[s].mode = lcr_pkg::MODE_ZERO;
          end else begin
            nx[s].numer = lcr_pkg::NUM_W'(cur[s].ss.root - lcr_pkg::ROOT_W'(cur[s].al));
          end
          nx[s].dv = {cur[s].aq, 1'b0};
        end else begin
          nx[s].dv = {1'b0, cur[s].al};
        end
      end else if (s == lcr_pkg::ST_FS + 1) begin
        // quotient above 32 bits shows as numerator top part not below divisor
        top         = lcr_pkg::CMP_W'(cur[s].numer >> (lcr_pkg::FIELD_W - lcr_pkg::FRAC_BITS));
        nx[s].sat   = (top >= lcr_pkg::CMP_W'(cur[s].dv));
        nx[s].drem  = top[lcr_pkg::DIV_W-1:0];
        nx[s].fnum  = lcr_pkg::FIELD_W'(cur[s].numer[lcr_pkg::FIELD_W-lcr_pkg::FRAC_BITS-1:0])
                      << lcr_pkg::FRAC_BITS;
        nx[s].q     = '0;
      end else begin
        dr          = lcr_pkg::div_step(cur[s].drem, cur[s].dv, cur[s].fnum[lcr_pkg::FIELD_W-1]);
        nx[s].drem  = dr[lcr_pkg::DIV_W:1];
        nx[s].q     = {cur[s].q[lcr_pkg::FIELD_W-2:0], dr[0]};
        nx[s].fnum  = cur[s].fnum << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= cur_vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[s] <= nx[s];
      end
    end
  end

  assign out_vld = vld[lcr_pkg::DEPTH-1];

  always_comb begin
    out_res = '0;
    case (st[lcr_pkg::DEPTH-1].mode)
      lcr_pkg::MODE_BYPASS: begin
        out_res.radius = st[lcr_pkg::DEPTH-1].preset;
      end
      lcr_pkg::MODE_FALLBACK: begin
        out_res.radius        = cfg.fallback;
        out_res.used_fallback = 1'b1;
      end
      lcr_pkg::MODE_ZERO: begin
        out_res.clipped = 1'b1;
      end
      lcr_pkg::MODE_LINEAR, lcr_pkg::MODE_QUAD: begin
        if (st[lcr_pkg::DEPTH-1].sat) begin
          out_res.radius  = '1;
          out_res.clipped = 1'b1;
        end else begin
          out_res.radius = st[lcr_pkg::DEPTH-1].q;
        end
      end
      default: begin
        out_res = '0;
      end
    endcase
  end

endmodule

FILE: rtl/light_cutoff_radius_unit.sv
// Cutoff radius of an attenuated light, one light per transfer. A nonzero
// preset radius passes straight through; otherwise the intensity magnitude is
// divided by the cutoff level (halved in hdr mode) and the attenuation curve
// is solved for the distance at that threshold, with the fallback radius for
// unbounded lights. The datapath is a 180-stage pipeline that takes a new
// light every cycle unless in_stall is raised; each square root produces one
// result bit per stage and each divide one quotient bit per stage.
// A two-entry output buffer keeps input transfers going while a result waits.
// Configuration writes are always ready and should only be made while no
// light is in flight.
module light_cutoff_radius_unit (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lcr_pkg::FIELD_W-1:0]   preset_radius,
  input  logic [lcr_pkg::FIELD_W-1:0]   intensity_red,
  input  logic [lcr_pkg::FIELD_W-1:0]   intensity_green,
  input  logic [lcr_pkg::FIELD_W-1:0]   intensity_blue,
  input  logic [lcr_pkg::FIELD_W-1:0]   atten_constant,
  input  logic [lcr_pkg::FIELD_W-1:0]   atten_linear,
  input  logic [lcr_pkg::FIELD_W-1:0]   atten_quadratic,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lcr_pkg::FIELD_W-1:0]   radius,
  output logic                          used_fallback,
  output logic                          clipped,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcr_pkg::FIELD_W-1:0]   cfg_data
);

  lcr_pkg::lcr_cfg_t    cfg;
  lcr_pkg::lcr_item_t   in_item;
  lcr_pkg::lcr_result_t pipe_res;
  logic                 pipe_vld;
  logic                 en;

  // output buffer
  lcr_pkg::lcr_result_t fifo_mem [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic [1:0]           count_next;
  logic                 push;
  logic                 pop;

  // configuration registers, writes always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hdr      <= 1'b0;
      cfg.cutoff   <= lcr_pkg::RESET_CUTOFF;
      cfg.fallback <= lcr_pkg::RESET_FALLBACK;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lcr_pkg::CFG_HDR_MODE:        cfg.hdr      <= cfg_data[0];
        lcr_pkg::CFG_CUTOFF_LEVEL:    cfg.cutoff   <= cfg_data[lcr_pkg::CUT_W-1:0];
        lcr_pkg::CFG_FALLBACK_RADIUS: cfg.fallback <= cfg_data;
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // input item into the pipeline
  always_comb begin
    in_item        = '0;
    in_item.preset = preset_radius;
    in_item.ir     = intensity_red;
    in_item.ig     = intensity_green;
    in_item.ib     = intensity_blue;
    in_item.ac     = atten_constant;
    in_item.al     = atten_linear;
    in_item.aq     = atten_quadratic;
  end

  // pipeline moves unless the buffer is full and the output is held
  assign en       = (count != 2'd2) || !out_stall;
  assign in_stall = !en;

  lcr_pipe u_pipe (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_valid),
    .in_item (in_item),
    .cfg     (cfg),
    .out_vld (pipe_vld),
    .out_res (pipe_res)
  );

  assign push       = pipe_vld && en;
  assign pop        = out_valid && !out_stall;
  assign count_next = count + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= pipe_res;
    end
  end

  // result transfer from the head of the buffer
  assign out_valid     = (count != 2'd0);
  assign radius        = fifo_mem[rd_ptr].radius;
  assign used_fallback = fifo_mem[rd_ptr].used_fallback;
  assign clipped       = fifo_mem[rd_ptr].clipped;

endmodule

FILE: rtl/lcr_checker.sv
module lcr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [lcr_pkg::FIELD_W-1:0]   radius,
  input logic                          used_fallback,
  input logic                          clipped
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(radius) &&
                               $stable(used_fallback) && $stable(clipped))
    else $error("stalled result changed");

  // input is only held back when a result is waiting on a stalled output
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // a clipped radius is either zero or saturated
  a_clip_val: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> (radius == '0) || (radius == '1))
    else $error("clipped radius not at a limit");

  // fallback and clipping never come together
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(used_fallback && clipped))
    else $error("fallback and clipped both set");

endmodule

bind light_cutoff_radius_unit lcr_checker u_lcr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .radius        (radius),
  .used_fallback (used_fallback),
  .clipped       (clipped)
);
